// File: src/bcde_pkg.sv
// ---------------------------------------------------------------------------
// bcde_pkg
// Shared types and constants for the binary cross dilate/erode block.
// ---------------------------------------------------------------------------
`default_nettype none

package bcde_pkg;

  localparam int PIX_W         = 8;
  localparam int THR_W         = 8;
  localparam int FW_W          = 11;
  localparam int FH_W          = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 12;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int Q_DEPTH       = 4;

  localparam logic [THR_W-1:0] THR_RESET = 8'd100;
  localparam logic             MODE_RESET = 1'b0;
  localparam logic [FW_W-1:0]  FW_RESET  = 11'd640;
  localparam logic [FH_W-1:0]  FH_RESET  = 12'd480;
  localparam logic [PIX_W-1:0] PIX_FG    = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BG    = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // one input pixel's worth of results: beat a always, beat b when dual
  typedef struct packed {
    logic dual;
    logic a_bit;
    logic a_fend;
    logic b_bit;
    logic b_fend;
  } bcde_job_t;

endpackage

`default_nettype wire

// File: src/bcde_ifs.sv
// ---------------------------------------------------------------------------
// bcde_ifs
// Valid/ready channels: gray pixel in, result pixel out, register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface bcde_pix_if import bcde_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bcde_res_if import bcde_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_run;
  logic             frame_end;
  modport source (output valid, output pixel_out, output last_of_run, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input last_of_run, input frame_end,
                  output ready);
endinterface

interface bcde_cfg_if import bcde_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/bcde_front.sv
// ---------------------------------------------------------------------------
// bcde_front
// Config registers, binarize, line buffers and window, result bits per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module bcde_front import bcde_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bcde_pix_if.sink   in_ch,
  bcde_cfg_if.sink   cfg,
  input  wire logic  q_full,
  output logic       job_push,
  output bcde_job_t  job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [THR_W-1:0] thr;
  logic             mode;
  logic [FW_W-1:0]  fw;
  logic [FH_W-1:0]  fh;

  logic [CW-1:0]    col;
  logic [FH_W-1:0]  row;
  logic             left_bit;

  logic             prior_mem [MAX_WIDTH];
  logic             older_mem [MAX_WIDTH];
  logic             cen_q;
  logic             rgt_q;
  logic             up_q;

  logic             acc;
  logic [XW-1:0]    fw_x;
  logic [CW-1:0]    last_c;
  logic [FH_W-1:0]  last_r;
  logic             last_col;
  logic             last_row;
  logic             b;
  logic             right;
  logic             border;
  logic             res;
  logic [CW-1:0]    nxt;
  logic [CW-1:0]    nxt_r;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THR_RESET;
      mode <= MODE_RESET;
      fw   <= FW_RESET;
      fh   <= FH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD: thr  <= cfg.data[THR_W-1:0];
        REG_MODE:      mode <= cfg.data[0];
        REG_WIDTH:     fw   <= cfg.data[FW_W-1:0];
        REG_HEIGHT:    fh   <= cfg.data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_x = XW'(fw);
    if (fw == '0) begin
      last_c = '0;
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      last_c = CW'(MAX_WIDTH - 1);
    end else begin
      last_c = CW'(fw_x - XW'(1));
    end
    last_r   = (fh == '0) ? '0 : fh - FH_W'(1);
    last_col = col >= last_c;
    last_row = row >= last_r;
    b        = in_ch.pixel_in > thr;
    right    = last_col ? 1'b0 : rgt_q;
    border   = (row == FH_W'(1)) || last_col || (col == '0);
    if (border) begin
      res = cen_q;
    end else if (mode == MODE_DILATE) begin
      res = cen_q | up_q | left_bit | right | b;
    end else begin
      res = cen_q & up_q & left_bit & right & b;
    end
    nxt   = last_col ? '0 : col + CW'(1);
    nxt_r = (nxt == CW'(MAX_WIDTH - 1)) ? '0 : nxt + CW'(1);
  end

  // line buffers, write-first so a one-pixel row sees its own write
  always_ff @(posedge clk) begin
    if (acc) begin
      prior_mem[col] <= b;
      older_mem[col] <= cen_q;
      cen_q <= (nxt == col)   ? b     : prior_mem[nxt];
      rgt_q <= (nxt_r == col) ? b     : prior_mem[nxt_r];
      up_q  <= (nxt == col)   ? cen_q : older_mem[nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      left_bit <= 1'b0;
    end else if (acc) begin
      col      <= nxt;
      left_bit <= last_col ? 1'b0 : cen_q;
      if (last_col) begin
        row <= last_row ? '0 : row + FH_W'(1);
      end
    end
  end

  always_comb begin
    job_push = acc && ((row != '0) || last_row);
    if (row != '0) begin
      job.dual   = last_row;
      job.a_bit  = res;
      job.a_fend = 1'b0;
    end else begin
      job.dual   = 1'b0;
      job.a_bit  = b;
      job.a_fend = last_col;
    end
    job.b_bit  = b;
    job.b_fend = last_col;
  end

endmodule

`default_nettype wire

// File: src/bcde_fifo.sv
// ---------------------------------------------------------------------------
// bcde_fifo
// Short job queue between the front and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module bcde_fifo import bcde_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire bcde_job_t  din,
  input  wire logic       pop,
  output bcde_job_t       dout,
  output logic            not_empty,
  output logic            full
);

  localparam int PW = $clog2(Q_DEPTH);

  bcde_job_t       slot [Q_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign not_empty = count != '0;
  assign full      = count == (PW+1)'(Q_DEPTH);
  assign dout      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bcde_emit.sv
// ---------------------------------------------------------------------------
// bcde_emit
// Output register: splits a job into one or two result beats.
// ---------------------------------------------------------------------------
`default_nettype none

module bcde_emit import bcde_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire bcde_job_t  job,
  input  wire logic       job_valid,
  output logic            pop,
  bcde_res_if.source      out_ch
);

  logic out_valid;
  logic out_bit;
  logic out_last;
  logic out_fend;
  logic pend;
  logic pend_bit;
  logic pend_fend;
  logic load;

  assign load               = !out_valid || out_ch.ready;
  assign pop                = load && !pend && job_valid;
  assign out_ch.valid       = out_valid;
  assign out_ch.pixel_out   = out_bit ? PIX_FG : PIX_BG;
  assign out_ch.last_of_run = out_last;
  assign out_ch.frame_end   = out_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (job_valid) begin
        out_valid <= 1'b1;
        pend      <= job.dual;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_bit  <= pend_bit;
        out_last <= 1'b1;
        out_fend <= pend_fend;
      end else begin
        out_bit   <= job.a_bit;
        out_last  <= !job.dual;
        out_fend  <= job.a_fend;
        pend_bit  <= job.b_bit;
        pend_fend <= job.b_fend;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/binary_cross_dilate_erode.sv
// ---------------------------------------------------------------------------
// binary_cross_dilate_erode
// Binarize gray pixels, then 3x3 cross dilation or erosion, streaming.
// ---------------------------------------------------------------------------
//  channel  dir  beat
//  in_ch    in   pixel_in[7:0]
//  out_ch   out  pixel_out[7:0], last_of_run, frame_end
//  cfg      in   index[2:0] (0 thr, 1 mode, 2 width, 3 height), data[11:0]
//
//  One pixel per clock while the job queue has room; a beat of row r yields
//  the row r-1 result through the job queue and then the output register.
//  Last row: two result beats per pixel from the single output register, so
//  input is held back once the job queue fills.
//  rst is synchronous; line buffers hold no reset, no clearing pass.
//  Either side may stall: the 4-entry job queue decouples them.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_cross_dilate_erode import bcde_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bcde_pix_if.sink    in_ch,
  bcde_res_if.source  out_ch,
  bcde_cfg_if.sink    cfg
);

  bcde_job_t job_in;
  bcde_job_t job_out;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_has;

  bcde_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_full   (q_full),
    .job_push (push),
    .job      (job_in)
  );

  bcde_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (job_in),
    .pop       (pop),
    .dout      (job_out),
    .not_empty (q_has),
    .full      (q_full)
  );

  bcde_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_valid (q_has),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: src/bcde_check.sv
// ---------------------------------------------------------------------------
// bcde_check
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bcde_check import bcde_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] pixel_out,
  input wire logic             last_of_run,
  input wire logic             frame_end
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out)
      && $stable(last_of_run) && $stable(frame_end))
    else $error("result beat changed while stalled");

  a_binary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_out == PIX_FG) || (pixel_out == PIX_BG))
    else $error("result pixel not binary");

  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_of_run)
    else $error("frame end on a non-final beat");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind binary_cross_dilate_erode bcde_check u_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_out   (out_ch.pixel_out),
  .last_of_run (out_ch.last_of_run),
  .frame_end   (out_ch.frame_end)
);

`default_nettype wire

// File: bench/binary_cross_dilate_erode_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_cross_dilate_erode_tb
// Streams gray frames through the binarize + cross dilate/erode block and
// checks every result beat against a cycle-free predictor of the same
// pipeline. Short directed frames first, then random frames with random
// geometry, threshold and mode, random gaps on both channels and one long
// output hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------

module binary_cross_dilate_erode_tb;
  import bcde_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned WIDE_AT       = 400;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned MAX_PRINTED   = 50;
  localparam longint     TIMEOUT_NS     = 10_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_BASE = REG_HEIGHT + 3'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_of_run;
    logic             frame_end;
  } morph_beat_t;

  class morph_scoreboard;
    bit               older_row [MAX_WIDTH_DEF];
    bit               prior_row [MAX_WIDTH_DEF];
    int unsigned      col;
    int unsigned      row;
    bit               left_bit;
    logic [THR_W-1:0] threshold;
    logic             mode;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    morph_beat_t      awaited [$];
    int unsigned      pixels_noted;
    int unsigned      errors;

    function new();
      col = 0;
      row = 0;
      left_bit = 1'b0;
      threshold = THR_RESET;
      mode = MODE_RESET;
      width_reg = FW_RESET;
      height_reg = FH_RESET;
      pixels_noted = 0;
      errors = 0;
    endfunction

    function int unsigned width_eff();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_THRESHOLD: threshold = value[THR_W-1:0];
        REG_MODE:      mode = value[0];
        REG_WIDTH:     width_reg = value[FW_W-1:0];
        REG_HEIGHT:    height_reg = value[FH_W-1:0];
        default: ;
      endcase
    endfunction

    // one gray beat in: row r-1 result for this column, plus the pixel
    // itself when this is the last row
    function void note_pixel(logic [PIX_W-1:0] gray);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      bit          last_col;
      bit          last_row;
      bit          fg;
      bit          center;
      bit          up;
      bit          right;
      bit          res;
      morph_beat_t beat;
      w = width_eff();
      h = (height_reg == 0) ? 1 : height_reg;
      c = col % MAX_WIDTH_DEF;
      r = row;
      last_col = c >= w - 1;
      last_row = r >= h - 1;
      fg = gray > threshold;
      center = prior_row[c];
      up = older_row[c];
      right = (!last_col && c + 1 < MAX_WIDTH_DEF) ? prior_row[c + 1] : 1'b0;
      pixels_noted++;
      if (r > 0) begin
        if (r == 1 || last_col || c == 0) begin
          res = center;
        end else if (mode == MODE_DILATE) begin
          res = center | up | left_bit | right | fg;
        end else begin
          res = center & up & left_bit & right & fg;
        end
        beat.pixel = res ? PIX_FG : PIX_BG;
        beat.last_of_run = !last_row;
        beat.frame_end = 1'b0;
        awaited.push_back(beat);
      end
      if (last_row) begin
        beat.pixel = fg ? PIX_FG : PIX_BG;
        beat.last_of_run = 1'b1;
        beat.frame_end = last_col;
        awaited.push_back(beat);
      end
      older_row[c] = center;
      prior_row[c] = fg;
      left_bit = center;
      if (last_col) begin
        col = 0;
        left_bit = 1'b0;
        row = last_row ? 0 : ((r + 1) & 32'hFFF);
      end else begin
        col = c + 1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(morph_beat_t got);
      morph_beat_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result beat pixel_out=%0d", got.pixel));
      end else begin
        want = awaited.pop_front();
        if (got.pixel !== want.pixel)
          report($sformatf("pixel_out got %0d want %0d", got.pixel, want.pixel));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run got %0b want %0b", got.last_of_run, want.last_of_run));
        if (got.frame_end !== want.frame_end)
          report($sformatf("frame_end got %0b want %0b", got.frame_end, want.frame_end));
      end
    endtask

    task check_leftovers();
      if (awaited.size() != 0)
        report($sformatf("%0d result beats never arrived", awaited.size()));
    endtask
  endclass

  logic clk;
  logic rst;

  bcde_pix_if pix_if ();
  bcde_res_if res_if ();
  bcde_cfg_if cfg_if ();

  binary_cross_dilate_erode dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (pix_if),
    .out_ch (res_if),
    .cfg    (cfg_if)
  );

  morph_scoreboard sb = new();

  bit          tx_steady;
  bit          in_wide;
  bit          wide_done;
  int unsigned random_items;
  morph_beat_t seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen.pixel = res_if.pixel_out;
      seen.last_of_run = res_if.last_of_run;
      seen.frame_end = res_if.frame_end;
      sb.check_result(seen);
    end
  end

  function automatic int unsigned idle_len(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] gray_sample(int unsigned density);
    logic [THR_W-1:0] thr;
    thr = sb.threshold;
    if ($urandom_range(0, 9) == 0) return PIX_W'($urandom);
    if ($urandom_range(1, 100) <= density && thr != '1)
      return PIX_W'($urandom_range(thr + 1, PIX_FG));
    return PIX_W'($urandom_range(0, thr));
  endfunction

  // result side: random stalls, steady stretches, one long hold-off
  initial begin : result_sink
    int unsigned stall;
    bit          steady;
    bit          held;
    steady = 1'b0;
    held = 1'b0;
    res_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = idle_len(steady);
      if (!held && in_wide && sb.pixels_noted >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] gray);
    int unsigned gap;
    gap = idle_len(tx_steady);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel_in <= PIX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_in <= gray;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_pixel(gray);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, value);
  endtask

  task automatic close_regs();
    cfg_if.valid <= 1'b0;
  endtask

  // stop input, wait for every awaited beat, then let first-row work settle
  task automatic quiesce();
    pix_if.valid <= 1'b0;
    do @(negedge clk); while (sb.awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup_frame();
    logic [CFG_DATA_W-1:0] value;
    int unsigned           roll;
    quiesce();
    in_wide = 1'b0;
    value = CFG_DATA_W'($urandom);
    roll = $urandom_range(0, 9);
    if (roll == 0) value[THR_W-1:0] = '0;
    else if (roll == 1) value[THR_W-1:0] = '1;
    if ($urandom_range(0, 1)) put_reg(REG_THRESHOLD, value);
    value = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1)) put_reg(REG_MODE, value);
    value = CFG_DATA_W'($urandom);
    if (!wide_done && random_items >= WIDE_AT) begin
      value[FW_W-1:0] = FW_W'($urandom_range(MAX_WIDTH_DEF, (1 << FW_W) - 1));
      in_wide = 1'b1;
      wide_done = 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      value[FW_W-1:0] = '0;
    end else begin
      value[FW_W-1:0] = FW_W'($urandom_range(1, 12));
    end
    put_reg(REG_WIDTH, value);
    if (in_wide) value = CFG_DATA_W'($urandom_range(0, 1));
    else if ($urandom_range(0, 19) == 0) value = '0;
    else value = CFG_DATA_W'($urandom_range(1, 8));
    put_reg(REG_HEIGHT, value);
    if ($urandom_range(0, 7) == 0)
      put_reg(REG_UNUSED_BASE | CFG_IDX_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom));
    close_regs();
  endtask

  // mid-frame change: width never grows so no unwritten line entry is read
  task automatic reshape_frame();
    int unsigned roll;
    quiesce();
    roll = $urandom_range(0, 3);
    if (roll == 0) put_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, sb.width_eff())));
    else if (roll == 1) put_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, sb.row + 2)));
    else if (roll == 2) put_reg(REG_MODE, CFG_DATA_W'($urandom));
    else put_reg(REG_THRESHOLD, CFG_DATA_W'($urandom));
    close_regs();
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] dilate_probe [9];
    int unsigned      fg_density;
    int unsigned      waited;
    dilate_probe = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0};
    tx_steady = 1'b0;
    in_wide = 1'b0;
    wide_done = 1'b0;
    random_items = 0;
    rst <= 1'b1;
    pix_if.valid <= 1'b0;
    pix_if.pixel_in <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_THRESHOLD;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 3x3 dilation, single foreground pixel right of center
    put_reg(REG_THRESHOLD, 0);
    put_reg(REG_MODE, MODE_DILATE);
    put_reg(REG_WIDTH, 3);
    put_reg(REG_HEIGHT, 3);
    close_regs();
    foreach (dilate_probe[i]) send_pixel(dilate_probe[i]);

    // 3x3 erosion, all foreground
    quiesce();
    put_reg(REG_THRESHOLD, 254);
    put_reg(REG_MODE, MODE_ERODE);
    close_regs();
    repeat (9) send_pixel(PIX_FG);

    // zero width and height: one-pixel frames
    quiesce();
    put_reg(REG_THRESHOLD, 255);
    put_reg(REG_WIDTH, 0);
    put_reg(REG_HEIGHT, 0);
    close_regs();
    send_pixel(PIX_FG);
    send_pixel(PIX_BG);

    // width past the line buffer, tallest frame, then cut both mid-frame
    quiesce();
    put_reg(REG_THRESHOLD, 127);
    put_reg(REG_WIDTH, 12'hFFF);
    put_reg(REG_HEIGHT, 12'hFFF);
    put_reg(REG_UNUSED_BASE, 12'hFFF);
    close_regs();
    send_pixel(128);
    send_pixel(127);
    send_pixel(0);
    quiesce();
    put_reg(REG_WIDTH, 2);
    put_reg(REG_HEIGHT, 2);
    close_regs();
    send_pixel(PIX_FG);
    send_pixel(200);
    send_pixel(50);

    fg_density = 50;
    while (random_items < RANDOM_ITEMS) begin
      if (sb.row == 0 && sb.col == 0) begin
        if (in_wide || $urandom_range(0, 9) < 7) setup_frame();
        fg_density = $urandom_range(0, 100);
      end else if (!in_wide && $urandom_range(0, 149) == 0) begin
        reshape_frame();
      end
      if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
      send_pixel(gray_sample(fg_density));
      random_items++;
    end

    pix_if.valid <= 1'b0;
    waited = 0;
    while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
src/bcde_pkg.sv
src/bcde_ifs.sv
src/bcde_front.sv
src/bcde_fifo.sv
src/bcde_emit.sv
src/binary_cross_dilate_erode.sv
src/bcde_check.sv
bench/binary_cross_dilate_erode_tb.sv
